@@ rtl/wrapped_radius_object_search_core_macros.svh @@
// Assertion helpers for wrapped_radius_object_search_core.sv.
// Each macro expects clk_i and rst_ni in scope.
`ifndef WRAPPED_RADIUS_OBJECT_SEARCH_CORE_MACROS_SVH
`define WRAPPED_RADIUS_OBJECT_SEARCH_CORE_MACROS_SVH

// Same-cycle implication.
`define WROS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WROS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wros_pkg.sv @@
`timescale 1ns / 1ps

package wros_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SLOT_W      = 6;
  localparam int COORD_W     = 16;
  localparam int RAD_W       = 15;
  localparam int REACH_W     = RAD_W + 1;
  localparam int ID_W        = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [SLOT_W:0]    DEPTH_EXT = (SLOT_W + 1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [ID_W-1:0]    MAX_ID    = ID_W'(TABLE_DEPTH);

  localparam logic [RAD_W-1:0] WRAP_LEFT_RST   = 15'd1000;
  localparam logic [RAD_W-1:0] WRAP_BOTTOM_RST = 15'd1000;
  localparam logic [RAD_W-1:0] WRAP_RIGHT_RST  = 15'd3000;
  localparam logic [RAD_W-1:0] WRAP_TOP_RST    = 15'd3000;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_ENABLE = 3'd0,
    CFG_WRAP_LEFT   = 3'd1,
    CFG_WRAP_BOTTOM = 3'd2,
    CFG_WRAP_RIGHT  = 3'd3,
    CFG_WRAP_TOP    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_FETCH,
    S_AXIS_X,
    S_AXIS_Y,
    S_MUL_R,
    S_MUL_X,
    S_MUL_Y,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RAD_W-1:0]          rad;
  } obj_t;

  typedef struct packed {
    logic [COORD_W:0] mag;
    logic             over;
  } axis_res_t;

endpackage

@@ rtl/wros_if.sv @@
`timescale 1ns / 1ps

interface wros_item_if import wros_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [RAD_W-1:0]          radius;
  logic                      present;

  modport source (output valid, opcode, slot, pos_x, pos_y, radius, present,
                  input ready);
  modport sink (input valid, opcode, slot, pos_x, pos_y, radius, present,
                output ready);
endinterface

interface wros_result_if import wros_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] object_id;
  logic            last;

  modport source (output valid, object_id, last, input ready);
  modport sink (input valid, object_id, last, output ready);
endinterface

@@ rtl/wrapped_radius_object_search_core.sv @@
// Channel   | Dir | Handshake       | Payload
// item_i    | in  | valid / ready   | opcode, slot, pos_x, pos_y, radius, present
// result_o  | out | valid / ready   | object_id, last
// cfg       | in  | cfg_we_i        | cfg_idx_i, cfg_data_i (write only)
//
// After a load, item_i stays ready for the next item. A query visits every
// slot: an absent slot is skipped, a slot may be rejected on an axis, or it
// gets the full square test (one shared 16x16 multiplier used three times).
// item_i is not ready while a query runs.
// rst_ni clears the present marks and the sequencer, and loads the wrap registers with their reset values.
// A stalled result_o holds the scan at the next match or at the end.
`timescale 1ns / 1ps
`include "wrapped_radius_object_search_core_macros.svh"

module wrapped_radius_object_search_core import wros_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wros_item_if.sink             item_i,
  wros_result_if.source         result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic             wrap_en_q;
  logic [RAD_W-1:0] wrap_left_q, wrap_bottom_q, wrap_right_q, wrap_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_en_q     <= 1'b0;
      wrap_left_q   <= WRAP_LEFT_RST;
      wrap_bottom_q <= WRAP_BOTTOM_RST;
      wrap_right_q  <= WRAP_RIGHT_RST;
      wrap_top_q    <= WRAP_TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WRAP_ENABLE: wrap_en_q     <= cfg_data_i[0];
        CFG_WRAP_LEFT:   wrap_left_q   <= cfg_data_i[RAD_W-1:0];
        CFG_WRAP_BOTTOM: wrap_bottom_q <= cfg_data_i[RAD_W-1:0];
        CFG_WRAP_RIGHT:  wrap_right_q  <= cfg_data_i[RAD_W-1:0];
        CFG_WRAP_TOP:    wrap_top_q    <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic in_xfer;
  logic load_we;
  logic out_free;

  assign item_i.ready = (state_q == S_IDLE);
  assign in_xfer      = item_i.valid && item_i.ready;
  // Slots past the table depth are dropped.
  assign load_we      = in_xfer && (item_i.opcode == OP_LOAD) &&
                        ({1'b0, item_i.slot} < DEPTH_EXT);

  // Object table: position and radius in a memory, present marks in flops
  obj_t                   obj_mem [TABLE_DEPTH];
  obj_t                   rd_q;
  logic [TABLE_DEPTH-1:0] present_q;
  logic [IDX_W-1:0]       idx_q, idx_d;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      obj_mem[item_i.slot[IDX_W-1:0]] <= '{x: item_i.pos_x, y: item_i.pos_y,
                                           rad: item_i.radius};
    end
    rd_q <= obj_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (load_we) begin
      present_q[item_i.slot[IDX_W-1:0]] <= item_i.present;
    end
  end

  // Query operands and per-slot working registers
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic [RAD_W-1:0]          qrad_q;
  logic [RAD_W-1:0]          dim_x_q, dim_y_q;
  logic [REACH_W-1:0]        reach_q, reach_sum;
  logic [COORD_W-1:0]        ax_q, ay_q;
  logic [2*COORD_W-1:0]      prod_q, rr_q, sqx_q;
  logic [COORD_W-1:0]        mul_op;
  logic                      in_reach;

  // Shared axis unit: x in AXIS_X, y in AXIS_Y
  logic signed [COORD_W-1:0] axis_obj, axis_ctr;
  logic [RAD_W-1:0]          axis_dim;
  logic [REACH_W-1:0]        axis_reach;
  axis_res_t                 axis_res;

  assign reach_sum  = REACH_W'(rd_q.rad) + REACH_W'(qrad_q);
  assign axis_obj   = (state_q == S_AXIS_Y) ? rd_q.y  : rd_q.x;
  assign axis_ctr   = (state_q == S_AXIS_Y) ? qy_q    : qx_q;
  assign axis_dim   = (state_q == S_AXIS_Y) ? dim_y_q : dim_x_q;
  assign axis_reach = (state_q == S_AXIS_Y) ? reach_q : reach_sum;

  wros_axis u_axis (
    .obj_i     (axis_obj),
    .ctr_i     (axis_ctr),
    .dim_i     (axis_dim),
    .wrap_en_i (wrap_en_q),
    .reach_i   (axis_reach),
    .res_o     (axis_res)
  );

  // Shared squarer: r*r, then ax*ax, then ay*ay
  always_comb begin
    unique case (state_q)
      S_MUL_R: mul_op = reach_q;
      S_MUL_X: mul_op = ax_q;
      default: mul_op = ay_q;
    endcase
  end

  assign in_reach = ({1'b0, sqx_q} + {1'b0, prod_q}) <= {1'b0, rr_q};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      qx_q   <= item_i.pos_x;
      qy_q   <= item_i.pos_y;
      qrad_q <= item_i.radius;
    end
    if (state_q == S_START) begin
      dim_x_q <= (wrap_left_q > wrap_right_q) ? wrap_left_q - wrap_right_q
                                              : wrap_right_q - wrap_left_q;
      dim_y_q <= (wrap_bottom_q > wrap_top_q) ? wrap_bottom_q - wrap_top_q
                                              : wrap_top_q - wrap_bottom_q;
    end
    if (state_q == S_AXIS_X) begin
      reach_q <= reach_sum;
      ax_q    <= axis_res.mag[COORD_W-1:0];
    end
    if (state_q == S_AXIS_Y) begin
      ay_q <= axis_res.mag[COORD_W-1:0];
    end
    prod_q <= mul_op * mul_op;
    if (state_q == S_MUL_X) begin
      rr_q <= prod_q;
    end
    if (state_q == S_MUL_Y) begin
      sqx_q <= prod_q;
    end
  end

  // Sequencer. A match waits in the pending register until the next match
  // or the end of the scan decides its last mark.
  logic            pend_valid_q, pend_valid_d;
  logic [ID_W-1:0] pend_id_q, pend_id_d;
  logic [ID_W-1:0] slot_id;
  logic            advance;
  logic            push;
  logic [ID_W-1:0] push_id;
  logic            push_last;

  assign slot_id = ID_W'(idx_q) + 1'b1;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    advance      = 1'b0;
    push         = 1'b0;
    push_id      = '0;
    push_last    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (item_i.opcode == OP_QUERY)) begin
          state_d = S_START;
          idx_d   = '0;
        end
      end
      S_START: state_d = S_FETCH;
      S_FETCH: begin
        if (present_q[idx_q]) begin
          state_d = S_AXIS_X;
        end else begin
          advance = 1'b1;
        end
      end
      S_AXIS_X: begin
        if (axis_res.over) begin
          advance = 1'b1;
        end else begin
          state_d = S_AXIS_Y;
        end
      end
      S_AXIS_Y: begin
        if (axis_res.over) begin
          advance = 1'b1;
        end else begin
          state_d = S_MUL_R;
        end
      end
      S_MUL_R: state_d = S_MUL_X;
      S_MUL_X: state_d = S_MUL_Y;
      S_MUL_Y: state_d = S_CHECK;
      S_CHECK: begin
        priority if (!in_reach) begin
          advance = 1'b1;
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_id_d    = slot_id;
          advance      = 1'b1;
        end else if (out_free) begin
          // Release the older match, hold the new one
          push      = 1'b1;
          push_id   = pend_id_q;
          pend_id_d = slot_id;
          advance   = 1'b1;
        end else begin
          // Hold the scan until the output register frees up
          advance = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          push         = 1'b1;
          push_id      = pend_valid_q ? pend_id_q : '0;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (advance) begin
      if (idx_q == LAST_IDX) begin
        state_d = S_DONE;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
  end

  // Output register: the scan runs on while one result waits for transfer
  logic            out_valid_q;
  logic [ID_W-1:0] out_id_q;
  logic            out_last_q;

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_id_q   <= push_id;
      out_last_q <= push_last;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.object_id = out_id_q;
  assign result_o.last      = out_last_q;

  `WROS_ASSERT_NOW(a_none_is_last, result_o.valid && (result_o.object_id == '0), result_o.last, "empty result without last")
  `WROS_ASSERT_NOW(a_id_in_table, result_o.valid, result_o.object_id <= MAX_ID, "object_id beyond table")
  `WROS_ASSERT_NOW(a_pend_in_query, pend_valid_q, state_q != S_IDLE, "pending match outside a query")
  `WROS_ASSERT_NOW(a_check_order, state_q == S_CHECK, ($past(state_q) == S_MUL_Y) || ($past(state_q) == S_CHECK), "check without squares")
  `WROS_ASSERT_NEXT(a_query_starts, in_xfer && (item_i.opcode == OP_QUERY), state_q == S_START, "query did not start")

endmodule

@@ rtl/wros_axis.sv @@
`timescale 1ns / 1ps

// Per-axis distance: difference, one wrap correction, magnitude, reach check.
module wros_axis import wros_pkg::*; (
  input  logic signed [COORD_W-1:0] obj_i,
  input  logic signed [COORD_W-1:0] ctr_i,
  input  logic [RAD_W-1:0]          dim_i,
  input  logic                      wrap_en_i,
  input  logic [REACH_W-1:0]        reach_i,
  output axis_res_t                 res_o
);

  logic signed [COORD_W+1:0] diff;
  logic signed [COORD_W+1:0] half_s;
  logic signed [COORD_W+1:0] dim_s;
  logic signed [COORD_W+1:0] wrapped;
  logic        [COORD_W+1:0] mag_full;

  always_comb begin
    diff   = (COORD_W + 2)'(obj_i) - (COORD_W + 2)'(ctr_i);
    dim_s  = signed'((COORD_W + 2)'(dim_i));
    half_s = signed'((COORD_W + 2)'(dim_i >> 1));
    priority if (wrap_en_i && (diff > half_s)) begin
      wrapped = diff - dim_s;
    end else if (wrap_en_i && (diff < -half_s)) begin
      wrapped = diff + dim_s;
    end else begin
      wrapped = diff;
    end
    mag_full  = wrapped[COORD_W+1] ? unsigned'(-wrapped) : unsigned'(wrapped);
    res_o.mag  = mag_full[COORD_W:0];
    res_o.over = res_o.mag > (COORD_W + 1)'(reach_i);
  end

endmodule
